// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted (active low).
`define SWFR_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SWFR_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/swfr_pkg.sv =====
// ----------------------------------------------------------------------------
// swfr_pkg
// Types and constants of the sync word frame receiver.
// ----------------------------------------------------------------------------
package swfr_pkg;

    localparam int SYNC_LEN  = 11;
    localparam int NUM_WORDS = 12;
    localparam int WORD_W    = 7;
    localparam int PAYLOAD_W = 56;
    localparam int CRC_W     = 16;

    localparam logic [SYNC_LEN-1:0] SYNC_WORD        = 11'h147;
    localparam logic [CRC_W-1:0]    CRC_POLY         = 16'h1021;
    localparam logic [7:0]          MIN_QUALITY_RST  = 8'd166;  // ~0.65 of full scale

    // word positions inside a frame
    localparam logic [3:0] WI_LABEL   = 4'd0;
    localparam logic [3:0] WI_REPEAT  = 4'd1;
    localparam logic [3:0] WI_LAST_CW = 4'd10;   // last full word of a data frame
    localparam logic [3:0] WI_CRC_END = 4'd11;   // 2-bit crc tail
    localparam logic [3:0] WI_CRC_MAX = 4'd8;    // last word fed to the crc
    localparam logic [3:0] WI_LIMIT   = 4'd12;

    // bit counts inside a word
    localparam logic [3:0] BIT_KEEP = 4'd7;
    localparam logic [3:0] BIT_WORD = 4'd9;
    localparam logic [3:0] BIT_TAIL = 4'd2;

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [2:0] {
        EV_SYNC       = 3'd0,
        EV_DATA_OK    = 3'd1,
        EV_ACK_OK     = 3'd2,
        EV_REJECT_OK  = 3'd3,
        EV_CRC_ERR    = 3'd4,
        EV_PARITY_ERR = 3'd5,
        EV_LABEL_ERR  = 3'd6,
        EV_SPARE      = 3'd7
    } t_event;

    typedef enum logic [1:0] {
        PFX_SPARE  = 2'd0,
        PFX_ACK    = 2'd1,
        PFX_REJECT = 2'd2,
        PFX_DATA   = 2'd3
    } t_prefix;

endpackage

// ===== sv/sync_word_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// sync_word_frame_receiver_top
// Hunts for the 11-bit sync word under a quality gate, then collects and checks
// data (CRC-16) or acknowledge/reject (repeated label, parity) frames.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | beat
//  in      | input     | i_in_valid / o_in_ready    | i_rx_bit, i_bit_quality
//  out     | output    | o_out_valid / i_out_ready  | o_event_res .. o_payload
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_min_sync_quality
//
// One beat per clock while the output is not stalled. A beat is held in the input
// register, is decoded in one pass (sync compare, running quality sum, one CRC
// step) and the event lands in the output register. A stalled output holds one
// event plus one queued input beat. Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
module sync_word_frame_receiver_top #(
    parameter int SYNC_AVG_LEN = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_rx_bit,
    input  logic [7:0]  i_bit_quality,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_event_res,
    output logic        o_direction,
    output logic        o_frame_type,
    output logic [2:0]  o_sequence_res,
    output logic [55:0] o_payload,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_min_sync_quality
);
    import swfr_pkg::*;

    `include "assert_macros.svh"

    localparam int SUM_W = $clog2(255 * SYNC_AVG_LEN + 1);

    // input register
    logic                 r_in_valid;
    logic                 r_in_bit;
    logic [7:0]           r_in_q;

    // receiver state
    logic [7:0]           r_min_q;
    logic [SYNC_LEN-1:0]  r_shift;
    logic [7:0]           r_hist [SYNC_AVG_LEN];
    logic [SUM_W-1:0]     r_sum;
    logic                 r_in_frame;
    logic [3:0]           r_word_idx;
    logic [3:0]           r_biw;
    t_word                r_store [NUM_WORDS];
    logic [CRC_W-1:0]     r_crc;

    // output register
    logic                 r_out_valid;
    t_event               r_event;
    logic                 r_dir;
    logic                 r_ftype;
    logic [2:0]           r_seq;
    logic [PAYLOAD_W-1:0] r_payload;

    // next values
    logic [SYNC_LEN-1:0]  n_shift;
    logic [SUM_W-1:0]     n_sum;
    logic [SUM_W-1:0]     thresh;
    logic                 n_in_frame;
    logic [3:0]           n_word_idx;
    logic [3:0]           n_biw;
    t_word                n_store [NUM_WORDS];
    logic [CRC_W-1:0]     n_crc;
    logic                 n_ev_valid;
    t_event               n_event;
    logic                 n_use_label;
    logic [PAYLOAD_W-1:0] n_payload;

    logic                 advance;
    logic                 sync_hit;
    logic                 crc_fb;
    t_word                label;
    t_prefix              prefix;
    logic [CRC_W-1:0]     crc_got;
    logic [1:0]           parity;

    // check terms
    logic                 ev_sync;
    logic                 ev_frame;
    logic                 frame_start;
    logic                 payload_ok;
    logic                 counters_ok;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    assign n_shift  = {r_shift[SYNC_LEN-2:0], r_in_bit};
    assign n_sum    = r_sum - r_hist[SYNC_AVG_LEN-1] + SUM_W'(r_in_q);
    assign thresh   = SUM_W'(r_min_q) * SUM_W'(SYNC_AVG_LEN);
    assign sync_hit = (n_shift == SYNC_WORD);
    assign label    = r_store[WI_LABEL];
    assign prefix   = t_prefix'(label[4:3]);
    assign parity   = {2{^label}};
    assign crc_fb   = r_crc[CRC_W-1] ^ r_in_bit;

    always_comb begin
        n_in_frame  = r_in_frame;
        n_word_idx  = r_word_idx;
        n_biw       = r_biw;
        n_store     = r_store;
        n_crc       = r_crc;
        n_ev_valid  = 1'b0;
        n_event     = EV_SYNC;
        n_use_label = 1'b0;
        n_payload   = '0;
        crc_got     = '0;

        if (sync_hit && n_sum >= thresh) begin
            n_in_frame = 1'b1;
            n_word_idx = '0;
            n_biw      = '0;
            n_crc      = '0;
            n_ev_valid = 1'b1;
            for (int i = 0; i < NUM_WORDS; i++) begin
                n_store[i] = '0;
            end
        end else if (!sync_hit && r_in_frame) begin
            if (r_word_idx >= WI_LIMIT) begin
                n_in_frame = 1'b0;
            end else begin
                n_biw = r_biw + 4'd1;
                if (n_biw <= BIT_KEEP) begin
                    n_store[r_word_idx] = {r_store[r_word_idx][WORD_W-2:0], r_in_bit};
                    if (r_word_idx <= WI_CRC_MAX) begin
                        n_crc = {r_crc[CRC_W-2:0], 1'b0} ^ (crc_fb ? CRC_POLY : '0);
                    end
                end
                crc_got = {r_store[9], r_store[10], n_store[WI_CRC_END][1:0]};

                if (r_word_idx == WI_LABEL) begin
                    if (n_biw == BIT_WORD) begin
                        n_biw      = '0;
                        n_word_idx = WI_REPEAT;
                        if (prefix == PFX_SPARE) begin
                            n_in_frame  = 1'b0;
                            n_ev_valid  = 1'b1;
                            n_event     = EV_SPARE;
                            n_use_label = 1'b1;
                        end
                    end
                end else if (prefix == PFX_DATA) begin
                    if (r_word_idx <= WI_LAST_CW) begin
                        if (n_biw == BIT_WORD) begin
                            n_biw      = '0;
                            n_word_idx = r_word_idx + 4'd1;
                        end
                    end else if (n_biw == BIT_TAIL) begin
                        n_biw       = '0;
                        n_in_frame  = 1'b0;
                        n_ev_valid  = 1'b1;
                        n_use_label = 1'b1;
                        if (crc_got == n_crc) begin
                            n_event = EV_DATA_OK;
                            for (int i = 1; i <= 8; i++) begin
                                n_payload[(8-i)*WORD_W +: WORD_W] = r_store[i];
                            end
                        end else begin
                            n_event = EV_CRC_ERR;
                        end
                    end
                end else if (r_word_idx == WI_REPEAT) begin
                    if (n_biw == BIT_WORD) begin
                        n_biw = '0;
                        if (r_store[WI_LABEL] != r_store[WI_REPEAT]) begin
                            n_in_frame  = 1'b0;
                            n_ev_valid  = 1'b1;
                            n_event     = EV_LABEL_ERR;
                            n_use_label = 1'b1;
                        end else begin
                            n_word_idx = r_word_idx + 4'd1;
                        end
                    end
                end else if (n_biw == BIT_TAIL) begin
                    n_biw       = '0;
                    n_in_frame  = 1'b0;
                    n_ev_valid  = 1'b1;
                    n_use_label = 1'b1;
                    if (parity == n_store[r_word_idx][1:0]) begin
                        n_event = (prefix == PFX_ACK) ? EV_ACK_OK : EV_REJECT_OK;
                    end else begin
                        n_event = EV_PARITY_ERR;
                    end
                end
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_bit <= i_rx_bit;
            r_in_q   <= i_bit_quality;
        end
    end

    // receiver state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_q    <= MIN_QUALITY_RST;
            r_shift    <= '0;
            r_sum      <= '0;
            r_in_frame <= 1'b0;
            r_word_idx <= '0;
            r_biw      <= '0;
            r_crc      <= '0;
            for (int i = 0; i < SYNC_AVG_LEN; i++) begin
                r_hist[i] <= '0;
            end
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_store[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_min_q <= i_cfg_min_sync_quality;
            end
            if (advance) begin
                // accepted sync also clears the hunt register
                r_shift    <= (n_ev_valid && n_event == EV_SYNC) ? '0 : n_shift;
                r_sum      <= n_sum;
                r_hist[0]  <= r_in_q;
                for (int i = 1; i < SYNC_AVG_LEN; i++) begin
                    r_hist[i] <= r_hist[i-1];
                end
                r_in_frame <= n_in_frame;
                r_word_idx <= n_word_idx;
                r_biw      <= n_biw;
                r_crc      <= n_crc;
                r_store    <= n_store;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_ev_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && n_ev_valid) begin
            r_event   <= n_event;
            r_dir     <= n_use_label & label[6];
            r_ftype   <= n_use_label & label[5];
            r_seq     <= n_use_label ? label[2:0] : 3'd0;
            r_payload <= n_payload;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_res    = r_event;
    assign o_direction    = r_dir;
    assign o_frame_type   = r_ftype;
    assign o_sequence_res = r_seq;
    assign o_payload      = r_payload;

    assign ev_sync     = advance && n_ev_valid && (n_event == EV_SYNC);
    assign ev_frame    = advance && n_ev_valid && (n_event != EV_SYNC);
    assign frame_start = r_in_frame && r_word_idx == WI_LABEL && r_biw == '0 && r_crc == '0;
    assign payload_ok  = !r_out_valid || r_event == EV_DATA_OK || r_payload == '0;
    assign counters_ok = r_biw <= BIT_WORD && r_word_idx <= WI_CRC_END;

    `SWFR_ASSERT(a_sync_restarts, i_clk, i_rst_n, ev_sync |=> frame_start, "no restart")
    `SWFR_ASSERT(a_result_ends_frame, i_clk, i_rst_n, ev_frame |=> !r_in_frame, "still in frame")
    `SWFR_ASSERT(a_payload_data_only, i_clk, i_rst_n, payload_ok, "payload on non-data event")
    `SWFR_ASSERT_ALWAYS(a_counters_range, i_clk, !i_rst_n || counters_ok, "counter range")

endmodule

// ===== tb/frame_rx_check_pkg.sv =====
// ----------------------------------------------------------------------------
// frame_rx_check_pkg
// Scoreboard for the sync word frame receiver. It keeps its own copy of the
// receiver state, turns each accepted input beat into the expected event and
// checks the events that come out of the block, oldest first.
// ----------------------------------------------------------------------------
package frame_rx_check_pkg;

    import swfr_pkg::*;

    localparam int QUALITY_WINDOW = 16;

    typedef struct packed {
        t_event               ev;
        logic                 dir;
        logic                 ftype;
        logic [2:0]           seq;
        logic [PAYLOAD_W-1:0] payload;
    } t_frame_result;

    // CRC-16 step, poly 0x1021, MSB first
    function automatic logic [CRC_W-1:0] crc16_step(input logic [CRC_W-1:0] c, input logic b);
        return {c[CRC_W-2:0], 1'b0} ^ ((c[CRC_W-1] ^ b) ? CRC_POLY : '0);
    endfunction

    class frame_rx_scoreboard;

        logic [7:0]          min_quality;
        logic [SYNC_LEN-1:0] sync_sr;
        logic [7:0]          q_hist [QUALITY_WINDOW];
        int unsigned         q_ptr;
        int unsigned         q_sum;
        bit                  in_frame;
        int unsigned         word_idx;
        int unsigned         bit_cnt;
        t_word               words [NUM_WORDS];
        logic [CRC_W-1:0]    crc;
        t_frame_result       pending [$];
        int unsigned         events_noted;
        int unsigned         mismatches;

        function new();
            min_quality  = MIN_QUALITY_RST;
            sync_sr      = '0;
            foreach (q_hist[i]) q_hist[i] = '0;
            q_ptr        = 0;
            q_sum        = 0;
            in_frame     = 1'b0;
            word_idx     = 0;
            bit_cnt      = 0;
            foreach (words[i]) words[i] = '0;
            crc          = '0;
            events_noted = 0;
            mismatches   = 0;
        endfunction

        function void set_min_quality(input logic [7:0] v);
            min_quality = v;
        endfunction

        function void push_event(input t_event ev, input t_word label,
                                 input logic [PAYLOAD_W-1:0] pl);
            t_frame_result r;
            r.ev      = ev;
            r.dir     = label[6];
            r.ftype   = label[5];
            r.seq     = label[2:0];
            r.payload = pl;
            pending.push_back(r);
            events_noted++;
        endfunction

        // one accepted input beat
        function void note_bit(input logic b, input logic [7:0] q);
            int unsigned          wi;
            t_word                label;
            t_prefix              pfx;
            logic [CRC_W-1:0]     got;
            logic [1:0]           par;
            logic [PAYLOAD_W-1:0] pl;

            sync_sr = {sync_sr[SYNC_LEN-2:0], b};
            q_sum = q_sum - q_hist[q_ptr] + q;
            q_hist[q_ptr] = q;
            q_ptr = (q_ptr + 1 >= QUALITY_WINDOW) ? 0 : q_ptr + 1;

            if (sync_sr == SYNC_WORD) begin
                // weak match: beat is dropped, frame in progress keeps going
                if (q_sum < int'(min_quality) * QUALITY_WINDOW)
                    return;
                sync_sr  = '0;
                in_frame = 1'b1;
                word_idx = 0;
                bit_cnt  = 0;
                foreach (words[i]) words[i] = '0;
                crc      = '0;
                push_event(EV_SYNC, '0, '0);
                return;
            end

            if (!in_frame)
                return;

            wi = word_idx;
            if (wi >= NUM_WORDS) begin
                in_frame = 1'b0;
                return;
            end
            bit_cnt++;
            if (bit_cnt <= BIT_KEEP) begin
                words[wi] = {words[wi][WORD_W-2:0], b};
                if (wi <= WI_CRC_MAX)
                    crc = crc16_step(crc, b);
            end

            label = words[WI_LABEL];
            pfx   = t_prefix'(label[4:3]);

            if (wi == WI_LABEL) begin
                if (bit_cnt == BIT_WORD) begin
                    bit_cnt  = 0;
                    word_idx = WI_REPEAT;
                    if (pfx == PFX_SPARE) begin
                        in_frame = 1'b0;
                        push_event(EV_SPARE, label, '0);
                    end
                end
                return;
            end

            if (pfx == PFX_DATA) begin
                if (wi <= WI_LAST_CW) begin
                    if (bit_cnt == BIT_WORD) begin
                        bit_cnt = 0;
                        word_idx++;
                    end
                    return;
                end
                if (bit_cnt == BIT_TAIL) begin
                    got = {words[9], words[10], words[WI_CRC_END][1:0]};
                    bit_cnt  = 0;
                    in_frame = 1'b0;
                    if (got == crc) begin
                        pl = '0;
                        for (int i = 1; i <= 8; i++)
                            pl = {pl[PAYLOAD_W-WORD_W-1:0], words[i]};
                        push_event(EV_DATA_OK, label, pl);
                    end else begin
                        push_event(EV_CRC_ERR, label, '0);
                    end
                end
                return;
            end

            if (wi == WI_REPEAT) begin
                if (bit_cnt == BIT_WORD) begin
                    bit_cnt = 0;
                    if (words[WI_LABEL] != words[WI_REPEAT]) begin
                        in_frame = 1'b0;
                        push_event(EV_LABEL_ERR, label, '0);
                        return;
                    end
                    word_idx = 2;
                end
                return;
            end

            if (bit_cnt == BIT_TAIL) begin
                par      = (^label) ? 2'b11 : 2'b00;
                bit_cnt  = 0;
                in_frame = 1'b0;
                if (par != words[2][1:0])
                    push_event(EV_PARITY_ERR, label, '0);
                else if (pfx == PFX_ACK)
                    push_event(EV_ACK_OK, label, '0);
                else
                    push_event(EV_REJECT_OK, label, '0);
            end
        endfunction

        task report(input string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_result(input logic [2:0] ev, input logic dir, input logic ftype,
                          input logic [2:0] seq, input logic [PAYLOAD_W-1:0] pl);
            t_frame_result want;
            if (pending.size() == 0) begin
                report($sformatf("event %0d with nothing outstanding", ev));
                return;
            end
            want = pending.pop_front();
            if (ev !== want.ev)
                report($sformatf("event got %0d want %s", ev, want.ev.name()));
            if (dir !== want.dir)
                report($sformatf("direction got %b want %b", dir, want.dir));
            if (ftype !== want.ftype)
                report($sformatf("frame type got %b want %b", ftype, want.ftype));
            if (seq !== want.seq)
                report($sformatf("sequence got %0d want %0d", seq, want.seq));
            if (pl !== want.payload)
                report($sformatf("payload got %h want %h", pl, want.payload));
        endtask

        task check_drained();
            if (pending.size() != 0)
                report($sformatf("%0d events never came out", pending.size()));
        endtask

    endclass

endpackage

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives bit/quality beats into the frame receiver: well-formed data, ack and
// reject frames with random content, broken frames, weak syncs and noise,
// under four threshold settings and four idle/stall patterns. Every output
// event is checked against the scoreboard.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import swfr_pkg::*;
    import frame_rx_check_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 16;
    localparam int PHASE_BITS    = 100;
    localparam int PHASE_EVENTS  = 4;
    localparam int NUM_PHASES    = 4;

    typedef enum {
        FK_DATA, FK_BAD_CRC, FK_ACK_REJ, FK_BAD_PARITY, FK_LABEL_MISMATCH,
        FK_SPARE, FK_CUT, FK_WEAK_SYNC, FK_NOISE
    } t_frame_kind;

    typedef enum {SG_STRONG, SG_WEAK, SG_AT_LIMIT, SG_BELOW_LIMIT} t_sync_grade;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_rx_bit;
    logic [7:0]           i_bit_quality;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [2:0]           o_event_res;
    logic                 o_direction;
    logic                 o_frame_type;
    logic [2:0]           o_sequence_res;
    logic [PAYLOAD_W-1:0] o_payload;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [7:0]           i_cfg_min_sync_quality;

    frame_rx_scoreboard sb;
    int                 send_idle_pct   = 0;
    int                 recv_stall_pct  = 0;
    logic [7:0]         cur_min_quality = MIN_QUALITY_RST;
    int unsigned        bits_sent       = 0;
    int unsigned        quiet_cycles    = 0;

    sync_word_frame_receiver_top u_top (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_rx_bit               (i_rx_bit),
        .i_bit_quality          (i_bit_quality),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_event_res            (o_event_res),
        .o_direction            (o_direction),
        .o_frame_type           (o_frame_type),
        .o_sequence_res         (o_sequence_res),
        .o_payload              (o_payload),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_min_sync_quality (i_cfg_min_sync_quality)
    );

    always #1 i_clk = ~i_clk;

    // beat monitors, receiver side and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            sb.note_bit(i_rx_bit, i_bit_quality);
        if (i_rst_n && i_cfg_valid && o_cfg_ready)
            sb.set_min_quality(i_cfg_min_sync_quality);
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_event_res, o_direction, o_frame_type, o_sequence_res,
                            o_payload);
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);

        if (i_rst_n && ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                        (i_cfg_valid && o_cfg_ready)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] rand_q();
        return 8'($urandom_range(255));
    endfunction

    function automatic t_word make_label(input t_prefix pfx);
        t_word l;
        l      = 7'($urandom_range(127));
        l[4:3] = pfx;
        return l;
    endfunction

    // quality of beat idx (0..15) of a pad+sync run
    function automatic logic [7:0] sync_quality(input t_sync_grade grade, input int idx);
        case (grade)
            SG_STRONG:   return 8'($urandom_range(255, cur_min_quality));
            SG_WEAK:     return (cur_min_quality == 0) ? rand_q() :
                                8'($urandom_range(cur_min_quality - 1));
            SG_AT_LIMIT: return cur_min_quality;
            default:     return (idx == 0 && cur_min_quality != 0) ?
                                cur_min_quality - 8'd1 : cur_min_quality;
        endcase
    endfunction

    task automatic send_bit(input logic b, input logic [7:0] q);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_rx_bit      <= b;
        i_bit_quality <= q;
        i_in_valid    <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        bits_sent++;
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_bit(1'($urandom_range(1)), rand_q());
    endtask

    // 7 kept bits MSB first, then two stop bits
    task automatic send_word(input t_word w);
        for (int i = WORD_W - 1; i >= 0; i--)
            send_bit(w[i], rand_q());
        send_noise(2);
    endtask

    // 5 pad beats + 11 sync beats fill the whole quality window
    task automatic send_sync(input t_sync_grade grade);
        for (int i = 0; i < 16; i++)
            send_bit((i < 5) ? 1'($urandom_range(1)) : SYNC_WORD[15 - i],
                     sync_quality(grade, i));
    endtask

    task automatic send_frame(input t_frame_kind kind, input t_word label,
                              input logic [PAYLOAD_W-1:0] data);
        logic [CRC_W-1:0] crc;
        t_word            rep_label;
        logic [1:0]       par;
        if (kind == FK_NOISE) begin
            send_noise($urandom_range(30, 1));
            return;
        end
        send_sync(SG_STRONG);
        case (kind)
            FK_DATA, FK_BAD_CRC: begin
                crc = '0;
                for (int i = WORD_W - 1; i >= 0; i--)
                    crc = crc16_step(crc, label[i]);
                for (int i = PAYLOAD_W - 1; i >= 0; i--)
                    crc = crc16_step(crc, data[i]);
                if (kind == FK_BAD_CRC)
                    crc = crc ^ (16'h0001 << $urandom_range(CRC_W - 1));
                send_word(label);
                for (int w = 0; w < 8; w++)
                    send_word(data[PAYLOAD_W - 1 - WORD_W * w -: WORD_W]);
                send_word(crc[15:9]);
                send_word(crc[8:2]);
                send_bit(crc[1], rand_q());
                send_bit(crc[0], rand_q());
            end
            FK_ACK_REJ, FK_BAD_PARITY, FK_LABEL_MISMATCH: begin
                rep_label = label;
                if (kind == FK_LABEL_MISMATCH)
                    rep_label = label ^ 7'($urandom_range(127, 1));
                par = (^label) ? 2'b11 : 2'b00;
                if (kind == FK_BAD_PARITY)
                    par = par ^ 2'($urandom_range(3, 1));
                send_word(label);
                send_word(rep_label);
                send_bit(par[1], rand_q());
                send_bit(par[0], rand_q());
            end
            FK_SPARE: send_word(label);
            FK_WEAK_SYNC: begin
                // a weak sync follows the strong one and is gated out unless the threshold is zero
                send_sync(SG_WEAK);
                send_noise($urandom_range(40, 1));
            end
            default: send_noise($urandom_range(60, 1));
        endcase
    endtask

    // hold the sender until the block has nothing left to report
    task automatic drain_results(input int settle);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_min_quality(input logic [7:0] v);
        i_cfg_min_sync_quality <= v;
        i_cfg_valid            <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid     <= 1'b0;
        cur_min_quality = v;
    endtask

    initial begin
        int unsigned bits_mark;
        int unsigned events_mark;
        int          r;
        t_frame_kind kind;
        t_word       lbl;

        sb = new();
        i_rst_n                <= 1'b0;
        i_in_valid             <= 1'b0;
        i_rx_bit               <= 1'b0;
        i_bit_quality          <= '0;
        i_cfg_valid            <= 1'b0;
        i_cfg_min_sync_quality <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                    write_min_quality(MIN_QUALITY_RST);
                end
                1: begin
                    send_idle_pct = 86; recv_stall_pct = 0;
                    write_min_quality(8'd255);
                end
                2: begin
                    send_idle_pct = 0;  recv_stall_pct = 86;
                    write_min_quality(8'd0);
                end
                default: begin
                    send_idle_pct = 28; recv_stall_pct = 28;
                    write_min_quality(8'($urandom_range(254, 1)));
                end
            endcase

            if (ph == 0) begin
                send_frame(FK_DATA, 7'h18, '0);
                send_frame(FK_DATA, 7'h7f, '1);
                send_frame(FK_BAD_CRC, 7'h3a, 56'({$urandom, $urandom}));
                send_frame(FK_ACK_REJ, 7'h08, '0);
                send_frame(FK_ACK_REJ, 7'h0f, '0);
                send_frame(FK_ACK_REJ, 7'h57, '0);
                send_frame(FK_BAD_PARITY, 7'h50, '0);
                send_frame(FK_LABEL_MISMATCH, 7'h2a, '0);
                send_frame(FK_SPARE, 7'h00, '0);
                send_frame(FK_SPARE, 7'h67, '0);
                send_sync(SG_BELOW_LIMIT);
                send_noise(20);
                send_sync(SG_AT_LIMIT);
                send_noise(20);
                send_frame(FK_WEAK_SYNC, '0, '0);
                // cut frame restarted by the next sync
                send_frame(FK_CUT, '0, '0);
                send_frame(FK_DATA, make_label(PFX_DATA), 56'({$urandom, $urandom}));
                send_frame(FK_NOISE, '0, '0);
                drain_results(SETTLE_CYCLES);
            end

            bits_mark   = bits_sent;
            events_mark = sb.events_noted;
            while (bits_sent - bits_mark < PHASE_BITS ||
                   sb.events_noted - events_mark < PHASE_EVENTS) begin
                r = $urandom_range(99);
                if (r < 25)      kind = FK_DATA;
                else if (r < 30) kind = FK_BAD_CRC;
                else if (r < 52) kind = FK_ACK_REJ;
                else if (r < 59) kind = FK_BAD_PARITY;
                else if (r < 66) kind = FK_LABEL_MISMATCH;
                else if (r < 72) kind = FK_SPARE;
                else if (r < 80) kind = FK_CUT;
                else if (r < 86) kind = FK_WEAK_SYNC;
                else             kind = FK_NOISE;
                case (kind)
                    FK_DATA, FK_BAD_CRC:                     lbl = make_label(PFX_DATA);
                    FK_ACK_REJ, FK_BAD_PARITY, FK_LABEL_MISMATCH:
                        lbl = make_label(t_prefix'($urandom_range(2, 1)));
                    FK_SPARE:                                lbl = make_label(PFX_SPARE);
                    default:                                 lbl = 7'($urandom_range(127));
                endcase
                send_frame(kind, lbl, 56'({$urandom, $urandom}));
                if ($urandom_range(15) == 0)
                    drain_results(SETTLE_CYCLES);
            end
            drain_results(SETTLE_CYCLES);
        end

        drain_results(END_CYCLES);
        sb.check_drained();
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
